@@ design/aopr_pkg.sv @@
// Shared types, constants and helper functions for the analogue output PWM regulator.
// Used by aopr_front, aopr_queue, aopr_back and analog_output_pwm_regulator.
// No dependencies.
package aopr_pkg;

    // Channel set and per-channel transmit range
    localparam int CHANNELS      = 3;
    localparam int RANGE_MAX_CH0 = 1000;
    localparam int RANGE_MAX_CH1 = 1000;
    localparam int RANGE_MAX_CH2 = 3000;

    // Wiring modes (code 3 is treated as 0-10V)
    localparam logic [1:0] MODE_CURRENT = 2'd0;
    localparam logic [1:0] MODE_5V      = 2'd1;

    // Target code end points
    localparam logic [11:0] CODE_I_MAX   = 12'd2730;
    localparam logic [11:0] CODE_I_MIN   = 12'd546;
    localparam logic [11:0] CODE_5V_MAX  = 12'd1732;
    localparam logic [11:0] CODE_10V_MAX = 12'd3464;
    localparam logic [11:0] CODE_LIMIT   = 12'd4095;

    localparam logic [7:0]  PID_FULL     = 8'd100;
    localparam int          PID_DEN      = 100;

    localparam logic [11:0] THRESH_RESET = 12'hff;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 3;
    localparam logic [2:0]  REG_USE_PID  = 3'd0;
    localparam logic [2:0]  REG_VOLT_CH0 = 3'd1;
    localparam logic [2:0]  REG_VOLT_CH1 = 3'd2;
    localparam logic [2:0]  REG_VOLT_CH2 = 3'd3;
    localparam logic [2:0]  REG_AMP_CH0  = 3'd4;
    localparam logic [2:0]  REG_AMP_CH1  = 3'd5;
    localparam logic [2:0]  REG_AMP_CH2  = 3'd6;

    // Divisor select for the span scaling
    localparam logic [1:0] DEN_CH0 = 2'd0;
    localparam logic [1:0] DEN_CH1 = 2'd1;
    localparam logic [1:0] DEN_CH2 = 2'd2;
    localparam logic [1:0] DEN_PID = 2'd3;

    // Span scaling: numerator below 2^15, span below 2^12, product below 2^27.
    // Division by reciprocal: ceil(2^(N+l)/d) is exact for every dividend below 2^N.
    localparam int NUM_W   = 15;
    localparam int SPAN_W  = 12;
    localparam int DIV_N   = NUM_W + SPAN_W;
    localparam int RECIP_W = DIV_N + 1;
    localparam int MULT_W  = DIV_N + RECIP_W;
    localparam int SHIFT_W = 6;

    localparam int SHIFT_CH0 = DIV_N + $clog2(RANGE_MAX_CH0);
    localparam int SHIFT_CH1 = DIV_N + $clog2(RANGE_MAX_CH1);
    localparam int SHIFT_CH2 = DIV_N + $clog2(RANGE_MAX_CH2);
    localparam int SHIFT_PID = DIV_N + $clog2(PID_DEN);

    localparam logic [RECIP_W-1:0] RECIP_CH0 = RECIP_W'(((64'd1 << SHIFT_CH0)
        + 64'(RANGE_MAX_CH0) - 64'd1) / 64'(RANGE_MAX_CH0));
    localparam logic [RECIP_W-1:0] RECIP_CH1 = RECIP_W'(((64'd1 << SHIFT_CH1)
        + 64'(RANGE_MAX_CH1) - 64'd1) / 64'(RANGE_MAX_CH1));
    localparam logic [RECIP_W-1:0] RECIP_CH2 = RECIP_W'(((64'd1 << SHIFT_CH2)
        + 64'(RANGE_MAX_CH2) - 64'd1) / 64'(RANGE_MAX_CH2));
    localparam logic [RECIP_W-1:0] RECIP_PID = RECIP_W'(((64'd1 << SHIFT_PID)
        + 64'(PID_DEN) - 64'd1) / 64'(PID_DEN));

    // Feedback measurement: current x*3000/4096, voltage x*60300/208896.
    // 208896 = 4096 * 51, so voltage is ((x*60300) >> 12) / 51.
    localparam int MEAS_I_SCALE = 3000;
    localparam int MEAS_V_SCALE = 60300;
    localparam int MEAS_V_DIV   = 208896;
    localparam int MEAS_PRE_SH  = 12;
    localparam int MEAS_V_REM   = MEAS_V_DIV / (1 << MEAS_PRE_SH);
    localparam int MEAS_MUL_W   = 28;
    localparam int MEAS_Y_W     = 16;
    localparam int MEAS_RSH     = MEAS_Y_W + $clog2(MEAS_V_REM);
    localparam int MEAS_RECIP_W = MEAS_Y_W + 1;
    localparam int MEAS_PROD_W  = MEAS_Y_W + MEAS_RECIP_W;
    localparam logic [MEAS_RECIP_W-1:0] MEAS_RECIP = MEAS_RECIP_W'(((64'd1 << MEAS_RSH)
        + 64'(MEAS_V_REM) - 64'd1) / 64'(MEAS_V_REM));
    localparam logic [11:0] MEAS_MAX = 12'(MEAS_I_SCALE - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 2;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);

    typedef logic signed [11:0] off_t;

    typedef struct packed {
        logic           use_pid;
        off_t [2:0]     volt_off;
        off_t [2:0]     amp_off;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [1:0]         chan;
        logic               is_cur;
        logic               sat;
        logic [11:0]        sat_code;
        logic [11:0]        base;
        logic [DIV_N-1:0]   prod;
        logic [1:0]         den_sel;
        logic [11:0]        fb;
    } q_entry_t;

    typedef struct packed {
        logic [1:0]  chan;
        logic [11:0] threshold;
        logic [11:0] target;
        logic [11:0] meas;
    } result_t;

    function automatic logic [14:0] range_max(input logic [1:0] chan);
        logic [14:0] r;
        begin
            unique case (chan)
                2'd0:    r = 15'(RANGE_MAX_CH0);
                2'd1:    r = 15'(RANGE_MAX_CH1);
                default: r = 15'(RANGE_MAX_CH2);
            endcase
            return r;
        end
    endfunction

    function automatic logic [RECIP_W-1:0] den_recip(input logic [1:0] sel);
        logic [RECIP_W-1:0] r;
        begin
            unique case (sel)
                DEN_CH0: r = RECIP_CH0;
                DEN_CH1: r = RECIP_CH1;
                DEN_CH2: r = RECIP_CH2;
                default: r = RECIP_PID;
            endcase
            return r;
        end
    endfunction

    function automatic logic [SHIFT_W-1:0] den_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] r;
        begin
            unique case (sel)
                DEN_CH0: r = SHIFT_W'(SHIFT_CH0);
                DEN_CH1: r = SHIFT_W'(SHIFT_CH1);
                DEN_CH2: r = SHIFT_W'(SHIFT_CH2);
                default: r = SHIFT_W'(SHIFT_PID);
            endcase
            return r;
        end
    endfunction

endpackage

@@ design/aopr_queue.sv @@
// Four-entry queue of classified items between front and back.
// Depends on aopr_pkg (q_entry_t, QUEUE_DEPTH).
module aopr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aopr_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output aopr_pkg::q_entry_t rdata,
    output logic               empty
);

    aopr_pkg::q_entry_t               mem_reg [aopr_pkg::QUEUE_DEPTH];
    logic [aopr_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [aopr_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [aopr_pkg::QPTR_W:0]        count_reg, count_next;

    assign full  = (count_reg == (aopr_pkg::QPTR_W+1)'(aopr_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/aopr_front.sv @@
// Front end: accepts items, drops invalid channels, picks the saturated code or
// forms numerator * span for the scaling. Depends on aopr_pkg.
module aopr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          chan,
    input  logic [1:0]          wiring_mode,
    input  logic signed [15:0]  sensor_value,
    input  logic [7:0]          pid_percent,
    input  logic [11:0]         feedback_code,
    input  logic                use_pid,
    output logic                q_push,
    output aopr_pkg::q_entry_t  q_entry,
    input  logic                q_full
);

    logic                valid_reg, valid_next;
    logic [1:0]          chan_reg;
    logic [1:0]          mode_reg;
    logic signed [15:0]  sval_reg;
    logic [7:0]          pct_reg;
    logic [11:0]         fb_reg;

    logic                chan_ok;
    logic                done;
    logic                accept;
    logic [11:0]         full_code;
    logic [11:0]         base;
    logic [11:0]         span;
    logic signed [15:0]  mx;
    logic [aopr_pkg::NUM_W-1:0] num;

    assign chan_ok = (chan_reg != 2'd3) && (32'(chan_reg) < aopr_pkg::CHANNELS);
    // an invalid channel leaves without a queue slot
    assign done    = !chan_ok || !q_full;
    assign full    = valid_reg && !done;
    assign accept  = push && !full;
    assign q_push  = valid_reg && chan_ok && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg <= chan;
            mode_reg <= wiring_mode;
            sval_reg <= sensor_value;
            pct_reg  <= pid_percent;
            fb_reg   <= feedback_code;
        end
    end

    // Classification
    always_comb
    begin
        case (mode_reg)
            aopr_pkg::MODE_CURRENT: full_code = aopr_pkg::CODE_I_MAX;
            aopr_pkg::MODE_5V:      full_code = aopr_pkg::CODE_5V_MAX;
            default:                full_code = aopr_pkg::CODE_10V_MAX;
        endcase
        base = (mode_reg == aopr_pkg::MODE_CURRENT) ? aopr_pkg::CODE_I_MIN : 12'd0;
        span = full_code - base;
        mx   = $signed({1'b0, aopr_pkg::range_max(chan_reg)});

        q_entry.chan     = chan_reg;
        q_entry.is_cur   = (mode_reg == aopr_pkg::MODE_CURRENT);
        q_entry.base     = base;
        q_entry.fb       = fb_reg;
        q_entry.sat      = 1'b0;
        q_entry.sat_code = base;
        q_entry.den_sel  = chan_reg;
        num              = '0;

        if (!use_pid)
        begin
            if (sval_reg >= mx)
            begin
                q_entry.sat      = 1'b1;
                q_entry.sat_code = full_code;
            end
            else if (sval_reg <= 16'sd0)
            begin
                q_entry.sat = 1'b1;
            end
            else
            begin
                num = sval_reg[aopr_pkg::NUM_W-1:0];
            end
        end
        else
        begin
            q_entry.den_sel = aopr_pkg::DEN_PID;
            if (pct_reg >= aopr_pkg::PID_FULL)
            begin
                q_entry.sat      = 1'b1;
                q_entry.sat_code = full_code;
            end
            else if (pct_reg == 8'd0)
            begin
                q_entry.sat = 1'b1;
            end
            else
            begin
                num = aopr_pkg::NUM_W'(pct_reg);
            end
        end

        q_entry.prod = aopr_pkg::DIV_N'(num) * aopr_pkg::DIV_N'(span);
    end

endmodule

@@ design/aopr_back.sv @@
// Back end: reciprocal division, offset and clamp, feedback measurement,
// threshold update and the result buffer. Depends on aopr_pkg.
module aopr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  aopr_pkg::cfg_t     cfg,
    input  aopr_pkg::q_entry_t q_entry,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [1:0]         out_chan,
    output logic [11:0]        pwm_threshold,
    output logic [11:0]        target_code,
    output logic [11:0]        measured_output
);

    typedef struct packed {
        logic [1:0]                    chan;
        logic                          is_cur;
        logic                          sat;
        logic [11:0]                   sat_code;
        logic [11:0]                   base;
        logic [11:0]                   fb;
        logic [1:0]                    den_sel;
        logic [aopr_pkg::MULT_W-1:0]   mprod;
        logic [11:0]                   corr;
        aopr_pkg::off_t                off;
    } s1_t;

    typedef struct packed {
        logic [1:0]                      chan;
        logic                            is_cur;
        logic [11:0]                     fb;
        logic [11:0]                     target;
        logic [aopr_pkg::MEAS_MUL_W-1:0] m1;
    } s2_t;

    typedef struct packed {
        logic [1:0]                       chan;
        logic                             is_cur;
        logic [11:0]                      target;
        logic                             up;
        logic                             nz;
        logic [11:0]                      step;
        logic [11:0]                      meas_cur;
        logic [aopr_pkg::MEAS_PROD_W-1:0] meas_prod;
    } s3_t;

    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    logic  adv;

    logic [11:0] th_reg [aopr_pkg::CHANNELS];

    aopr_pkg::result_t          obuf_reg [aopr_pkg::OUT_DEPTH];
    logic [aopr_pkg::OPTR_W-1:0] owr_reg, ord_reg;
    logic [aopr_pkg::OPTR_W:0]   ocount_reg, ocount_next;
    logic                        o_push, o_pop;
    aopr_pkg::result_t           o_item;

    aopr_pkg::off_t      off_sel;
    logic signed [13:0]  corr_w;
    logic [11:0]         quot;
    logic [11:0]         tpre;
    logic signed [13:0]  tsum;
    logic signed [12:0]  diff;
    logic [11:0]         mag;
    logic [aopr_pkg::MEAS_Y_W-1:0] meas_y;
    logic [11:0]         th_cur;
    logic [12:0]         th_sum;
    logic [11:0]         th_new;

    // whole pipeline steps together, held only by a full result buffer
    assign adv   = !s3_valid_reg || (ocount_reg < (aopr_pkg::OPTR_W+1)'(aopr_pkg::OUT_DEPTH));
    assign q_pop = adv && !q_empty;

    // Stage 1: reciprocal multiply, corrected feedback
    always_comb
    begin
        off_sel = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (q_entry.chan == 2'(i))
            begin
                off_sel = q_entry.is_cur ? cfg.amp_off[i] : cfg.volt_off[i];
            end
        end
        corr_w = $signed({2'b00, q_entry.fb}) - 14'(off_sel);

        s1_next.chan     = q_entry.chan;
        s1_next.is_cur   = q_entry.is_cur;
        s1_next.sat      = q_entry.sat;
        s1_next.sat_code = q_entry.sat_code;
        s1_next.base     = q_entry.base;
        s1_next.fb       = q_entry.fb;
        s1_next.den_sel  = q_entry.den_sel;
        s1_next.off      = off_sel;
        s1_next.mprod    = aopr_pkg::MULT_W'(q_entry.prod)
                         * aopr_pkg::MULT_W'(aopr_pkg::den_recip(q_entry.den_sel));
        if (corr_w < 14'sd0)
        begin
            s1_next.corr = 12'd0;
        end
        else if (corr_w > 14'sd4095)
        begin
            s1_next.corr = aopr_pkg::CODE_LIMIT;
        end
        else
        begin
            s1_next.corr = corr_w[11:0];
        end
    end

    // Stage 2: quotient, target with offset, first measurement product
    always_comb
    begin
        quot = 12'(s1_reg.mprod >> aopr_pkg::den_shift(s1_reg.den_sel));
        tpre = s1_reg.sat ? s1_reg.sat_code : s1_reg.base + quot;
        tsum = $signed({2'b00, tpre}) + 14'(s1_reg.off);

        s2_next.chan   = s1_reg.chan;
        s2_next.is_cur = s1_reg.is_cur;
        s2_next.fb     = s1_reg.fb;
        if (tsum < 14'sd0)
        begin
            s2_next.target = 12'd0;
        end
        else if (tsum > 14'sd4095)
        begin
            s2_next.target = aopr_pkg::CODE_LIMIT;
        end
        else
        begin
            s2_next.target = tsum[11:0];
        end
        s2_next.m1 = aopr_pkg::MEAS_MUL_W'(s1_reg.corr)
                   * (s1_reg.is_cur ? aopr_pkg::MEAS_MUL_W'(aopr_pkg::MEAS_I_SCALE)
                                    : aopr_pkg::MEAS_MUL_W'(aopr_pkg::MEAS_V_SCALE));
    end

    // Stage 3: error step, measurement scaling (voltage needs the /51)
    always_comb
    begin
        diff   = $signed({1'b0, s2_reg.target}) - $signed({1'b0, s2_reg.fb});
        mag    = (diff < 13'sd0) ? 12'(-diff) : 12'(diff);
        meas_y = aopr_pkg::MEAS_Y_W'(s2_reg.m1 >> aopr_pkg::MEAS_PRE_SH);

        s3_next.chan      = s2_reg.chan;
        s3_next.is_cur    = s2_reg.is_cur;
        s3_next.target    = s2_reg.target;
        s3_next.up        = (diff > 13'sd0);
        s3_next.nz        = (diff != 13'sd0);
        s3_next.step      = s2_reg.is_cur ? (mag >> 3) : (mag >> 1);
        s3_next.meas_cur  = 12'(s2_reg.m1 >> aopr_pkg::MEAS_PRE_SH);
        s3_next.meas_prod = aopr_pkg::MEAS_PROD_W'(meas_y)
                          * aopr_pkg::MEAS_PROD_W'(aopr_pkg::MEAS_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    // Threshold read-modify-write as the item leaves stage 3
    always_comb
    begin
        th_cur = aopr_pkg::THRESH_RESET;
        for (int i = 0; i < aopr_pkg::CHANNELS; i++)
        begin
            if (s3_reg.chan == 2'(i))
            begin
                th_cur = th_reg[i];
            end
        end
        th_sum = {1'b0, th_cur} + {1'b0, s3_reg.step};
        th_new = th_cur;
        if (s3_reg.nz)
        begin
            if (s3_reg.up)
            begin
                th_new = th_sum[12] ? aopr_pkg::CODE_LIMIT : th_sum[11:0];
            end
            else
            begin
                th_new = (th_cur > s3_reg.step) ? th_cur - s3_reg.step : 12'd0;
            end
        end

        o_item.chan      = s3_reg.chan;
        o_item.threshold = th_new;
        o_item.target    = s3_reg.target;
        o_item.meas      = s3_reg.is_cur ? s3_reg.meas_cur
                         : 12'(s3_reg.meas_prod >> aopr_pkg::MEAS_RSH);
    end

    assign o_push = s3_valid_reg && adv;
    assign o_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aopr_pkg::CHANNELS; i++)
            begin
                th_reg[i] <= aopr_pkg::THRESH_RESET;
            end
        end
        else if (o_push && s3_reg.nz)
        begin
            for (int i = 0; i < aopr_pkg::CHANNELS; i++)
            begin
                if (s3_reg.chan == 2'(i))
                begin
                    th_reg[i] <= th_new;
                end
            end
        end
    end

    // Result buffer
    always_comb
    begin
        ocount_next = ocount_reg;
        if (o_push && !o_pop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (o_pop && !o_push)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            if (o_push)
            begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (o_pop)
            begin
                ord_reg <= ord_reg + 1'b1;
            end
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_push)
        begin
            obuf_reg[owr_reg] <= o_item;
        end
    end

    assign empty           = (ocount_reg == '0);
    assign out_chan        = obuf_reg[ord_reg].chan;
    assign pwm_threshold   = obuf_reg[ord_reg].threshold;
    assign target_code     = obuf_reg[ord_reg].target;
    assign measured_output = obuf_reg[ord_reg].meas;

    a_ocount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg <= (aopr_pkg::OPTR_W+1)'(aopr_pkg::OUT_DEPTH))
        else $error("result buffer overfilled");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !adv) |=> (s3_valid_reg && $stable(s3_reg.target)
                                    && $stable(s3_reg.chan)))
        else $error("stalled item in stage 3 lost or changed");

    a_meas_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (measured_output <= aopr_pkg::MEAS_MAX))
        else $error("measured output out of range");

    a_chan_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((s3_reg.chan != 2'd3)
                          && (32'(s3_reg.chan) < aopr_pkg::CHANNELS)))
        else $error("invalid channel reached the threshold store");

endmodule

@@ design/analog_output_pwm_regulator.sv @@
// Top level of the analogue output PWM regulator: configuration registers and
// the front / queue / back split. Depends on aopr_pkg, aopr_front, aopr_queue, aopr_back.
//
// Usage:
//  - Input channel: an item (chan, wiring_mode, sensor_value, pid_percent,
//    feedback_code) is taken on a rising edge with push high and full low.
//  - Result channel: while empty is low the oldest result sits on out_chan,
//    pwm_threshold, target_code and measured_output; it leaves on a rising
//    edge with pop high.
//  - An item whose chan is not a valid channel is taken and yields no result.
//  - Path: an accepted item passes the front register, the queue, the three
//    back-end stages and the result buffer before its result shows.
//  - Throughput: one item per cycle while full stays low; the back end is a
//    three-stage pipeline and each multiplier is followed by a register.
//  - Configuration: cfg_wr_en / cfg_index / cfg_data write one register per
//    cycle; write only while no items are in flight.
//  - Reset: thresholds go to 255, offsets and PID select to 0, queues empty.
//  - Stall: when pop is held low the two-entry result buffer fills, the back
//    end freezes, the four-entry queue fills and then full rises.
module analog_output_pwm_regulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     chan,
    input  logic [1:0]                     wiring_mode,
    input  logic signed [15:0]             sensor_value,
    input  logic [7:0]                     pid_percent,
    input  logic [11:0]                    feedback_code,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     out_chan,
    output logic [11:0]                    pwm_threshold,
    output logic [11:0]                    target_code,
    output logic [11:0]                    measured_output,
    input  logic                           cfg_wr_en,
    input  logic [aopr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0]                    cfg_data
);

    aopr_pkg::cfg_t     cfg_reg, cfg_next;
    aopr_pkg::q_entry_t fq_entry;
    aopr_pkg::q_entry_t qb_entry;
    logic               fq_push;
    logic               fq_full;
    logic               qb_pop;
    logic               qb_empty;

    // Register decode; index 7 is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                aopr_pkg::REG_USE_PID:  cfg_next.use_pid     = cfg_data[0];
                aopr_pkg::REG_VOLT_CH0: cfg_next.volt_off[0] = cfg_data;
                aopr_pkg::REG_VOLT_CH1: cfg_next.volt_off[1] = cfg_data;
                aopr_pkg::REG_VOLT_CH2: cfg_next.volt_off[2] = cfg_data;
                aopr_pkg::REG_AMP_CH0:  cfg_next.amp_off[0]  = cfg_data;
                aopr_pkg::REG_AMP_CH1:  cfg_next.amp_off[1]  = cfg_data;
                aopr_pkg::REG_AMP_CH2:  cfg_next.amp_off[2]  = cfg_data;
                default:                cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: take and classify
    aopr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .chan          (chan),
        .wiring_mode   (wiring_mode),
        .sensor_value  (sensor_value),
        .pid_percent   (pid_percent),
        .feedback_code (feedback_code),
        .use_pid       (cfg_reg.use_pid),
        .q_push        (fq_push),
        .q_entry       (fq_entry),
        .q_full        (fq_full)
    );

    // Decoupling queue
    aopr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_entry),
        .full  (fq_full),
        .pop   (qb_pop),
        .rdata (qb_entry),
        .empty (qb_empty)
    );

    // Back: arithmetic, threshold store, result buffer
    aopr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_entry         (qb_entry),
        .q_empty         (qb_empty),
        .q_pop           (qb_pop),
        .pop             (pop),
        .empty           (empty),
        .out_chan        (out_chan),
        .pwm_threshold   (pwm_threshold),
        .target_code     (target_code),
        .measured_output (measured_output)
    );

endmodule
